// File: rtl/generational_handle_table_top_defines.svh
// Assertion helpers for the handle table datapath RTL.
`ifndef GENERATIONAL_HANDLE_TABLE_TOP_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define GHT_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define GHT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ght_pkg.sv
`default_nettype none

package ght_pkg;

   // Request codes
   typedef enum logic [1:0] {
      ACT_OPEN    = 2'd0,
      ACT_CHECK   = 2'd1,
      ACT_CLOSE   = 2'd2,
      ACT_INVALID = 2'd3
   } action_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_IDLE  = 2'd1,
      ST_EXEC  = 2'd2
   } state_type;

   // Result status codes
   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_FULL         = 3'd1;
   localparam logic [2:0] STATUS_NO_ACCESS    = 3'd2;
   localparam logic [2:0] STATUS_BAD_HANDLE   = 3'd3;
   localparam logic [2:0] STATUS_NOT_BORROWED = 3'd4;

   // Access kinds
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   localparam int GEN_W    = 16;
   localparam int SLOTF_W  = 16;
   localparam int REF_W    = 32;
   localparam int HANDLE_W = 32;

   localparam logic [GEN_W-1:0] GEN_INIT = 16'd1;

   // One stored slot record
   typedef struct packed {
      logic [GEN_W-1:0] gen;
      logic [1:0]       kind;
      logic             borrowed;
      logic [REF_W-1:0] obj_ref;
   } slot_rec_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic commit;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_done;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// File: rtl/ght_ctrl.sv
`default_nettype none

module ght_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ght_pkg::dp_status_type sts,
   output ght_pkg::dp_cmd_type    cmd
);
   import ght_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_stall    = 1'b1;
      cmd          = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_EXEC: begin
            cmd.commit = sts.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/ght_dp.sv
`default_nettype none
`include "generational_handle_table_top_defines.svh"

module ght_dp #(
   parameter int SLOTS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ght_pkg::dp_cmd_type    cmd,
   output ght_pkg::dp_status_type sts,
   input  logic [1:0]             req_action,
   input  logic [31:0]            req_handle,
   input  logic [1:0]             req_access_kind,
   input  logic                   req_borrowed,
   input  logic [31:0]            req_file_ref,
   input  logic                   req_only_if_borrowed,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_status,
   output logic [31:0]            rsp_handle_out,
   output logic [1:0]             rsp_kind_out,
   output logic                   rsp_borrowed_out,
   output logic [31:0]            rsp_ref_out
);
   import ght_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // Slot record memory and occupancy vector
   slot_rec_type           mem [SLOTS];
   slot_rec_type           rd_ff;
   logic [SLOTS-1:0]       used_ff, used_in;
   logic [IDX_W-1:0]       clr_idx_ff, clr_idx_in;

   // Captured request
   action_type             act_ff;
   logic [HANDLE_W-1:0]    handle_ff;
   logic [1:0]             kind_ff;
   logic                   borr_ff;
   logic [REF_W-1:0]       ref_ff;
   logic                   only_b_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic                   found_ff;
   logic                   in_range_ff;
   logic                   hit_used_ff;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             rsp_status_ff;
   logic [HANDLE_W-1:0]    rsp_handle_ff;
   logic [1:0]             rsp_kind_ff;
   logic                   rsp_borr_ff;
   logic [REF_W-1:0]       rsp_ref_ff;

   logic                   free_found;
   logic [IDX_W-1:0]       free_idx;
   logic [SLOTF_W-1:0]     enc;
   logic                   in_range;
   logic [IDX_W-1:0]       hit_idx;
   logic [IDX_W-1:0]       rd_addr;
   logic [1:0]             kind_norm;

   logic                   valid_h;
   logic [GEN_W-1:0]       gen_next;
   logic [2:0]             res_status;
   logic [HANDLE_W-1:0]    res_handle;
   logic [1:0]             res_kind;
   logic                   res_borr;
   logic [REF_W-1:0]       res_ref;
   logic                   wr_open, wr_close;

   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   slot_rec_type           mem_wdata;

   // Lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // Handle decode: slot field is index plus one, zero is never valid
   assign enc      = req_handle[SLOTF_W-1:0];
   assign in_range = (enc != '0) && ({1'b0, enc} <= (SLOTF_W + 1)'(SLOTS));
   assign hit_idx  = in_range ? IDX_W'(enc - 16'd1) : '0;
   assign rd_addr  = (action_type'(req_action) == ACT_OPEN) ? free_idx : hit_idx;

   // Kind 3 stores as write
   assign kind_norm = req_access_kind[1] ? KIND_WRITE :
                      (req_access_kind[0] ? KIND_READ : KIND_NONE);

   // Request code starts known so the outcome logic never decodes X
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= ACT_INVALID;
      end else if (cmd.accept) begin
         act_ff <= action_type'(req_action);
      end
   end

   // Capture request at accept
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         handle_ff   <= req_handle;
         kind_ff     <= kind_norm;
         borr_ff     <= req_borrowed;
         ref_ff      <= req_file_ref;
         only_b_ff   <= req_only_if_borrowed;
         idx_ff      <= rd_addr;
         found_ff    <= free_found;
         in_range_ff <= in_range;
         hit_used_ff <= in_range && used_ff[hit_idx];
      end
   end

   // Record memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (cmd.accept) rd_ff <= mem[rd_addr];
   end

   // Decide the item's outcome from the registered record
   assign valid_h  = in_range_ff && hit_used_ff && (rd_ff.gen == handle_ff[HANDLE_W-1:SLOTF_W]);
   assign gen_next = (rd_ff.gen == {GEN_W{1'b1}}) ? GEN_INIT : (rd_ff.gen + 16'd1);

   always_comb begin
      res_status = STATUS_OK;
      res_handle = '0;
      res_kind   = KIND_NONE;
      res_borr   = 1'b0;
      res_ref    = '0;
      wr_open    = 1'b0;
      wr_close   = 1'b0;
      unique case (act_ff)
         ACT_OPEN: begin
            if (kind_ff == KIND_NONE) begin
               res_status = STATUS_NO_ACCESS;
            end else if (!found_ff) begin
               res_status = STATUS_FULL;
            end else begin
               wr_open    = 1'b1;
               res_handle = {rd_ff.gen, SLOTF_W'(idx_ff) + 16'd1};
               res_kind   = kind_ff;
               res_borr   = borr_ff;
               res_ref    = ref_ff;
            end
         end
         ACT_CHECK, ACT_CLOSE: begin
            if (!valid_h) begin
               res_status = STATUS_BAD_HANDLE;
            end else begin
               res_kind = rd_ff.kind;
               res_borr = rd_ff.borrowed;
               res_ref  = rd_ff.obj_ref;
               if (act_ff == ACT_CLOSE) begin
                  if (only_b_ff && !rd_ff.borrowed) begin
                     res_status = STATUS_NOT_BORROWED;
                  end else begin
                     wr_close = 1'b1;
                  end
               end
            end
         end
         ACT_INVALID: begin
            res_status = STATUS_BAD_HANDLE;
         end
      endcase
   end

   // Memory write select: clearing pass, open, close
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = rd_ff;
      priority if (cmd.clear_wr) begin
         mem_we    = 1'b1;
         mem_waddr = clr_idx_ff;
         mem_wdata = '{gen: GEN_INIT, kind: KIND_NONE, borrowed: 1'b0, obj_ref: '0};
      end else if (cmd.commit && wr_open) begin
         mem_we    = 1'b1;
         mem_wdata = '{gen: rd_ff.gen, kind: kind_ff, borrowed: borr_ff, obj_ref: ref_ff};
      end else if (cmd.commit && wr_close) begin
         mem_we    = 1'b1;
         mem_wdata = '{gen: gen_next, kind: KIND_NONE, borrowed: 1'b0,
                       obj_ref: rd_ff.obj_ref};
      end
   end

   // Occupancy update
   always_comb begin
      used_in = used_ff;
      if (cmd.commit && wr_open) used_in[idx_ff] = 1'b1;
      if (cmd.commit && wr_close) used_in[idx_ff] = 1'b0;
   end

   // Clearing pass counter
   assign clr_idx_in     = cmd.clear_wr ? (clr_idx_ff + IDX_W'(1)) : clr_idx_ff;
   assign sts.clear_done = (clr_idx_ff == LAST_IDX);

   // Result register takes a new item when empty or being drained
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= res_status;
         rsp_handle_ff <= res_handle;
         rsp_kind_ff   <= res_kind;
         rsp_borr_ff   <= res_borr;
         rsp_ref_ff    <= res_ref;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_handle_out   = rsp_handle_ff;
   assign rsp_kind_out     = rsp_kind_ff;
   assign rsp_borrowed_out = rsp_borr_ff;
   assign rsp_ref_out      = rsp_ref_ff;

   // Checks
   `GHT_ASSERT_IMPL(a_commit_needs_room, clock, reset, cmd.commit, sts.out_free, "commit blocked")
   `GHT_ASSERT_IMPL(a_no_accept_in_clear, clock, reset, cmd.clear_wr, !cmd.accept, "accept in clear")
   `GHT_ASSERT_NEXT(a_open_marks_used, clock, reset, cmd.commit && wr_open, used_ff[idx_ff], "open")
   `GHT_ASSERT_NEXT(a_close_frees_slot, clock, reset, cmd.commit && wr_close, !used_ff[idx_ff], "close")

endmodule

`default_nettype wire

// File: rtl/generational_handle_table_top.sv
// Generational handle table.
// Request channel (req_valid / req_stall): action 0 opens a handle in the
// lowest free slot, 1 checks a handle, 2 closes it. Each request yields
// exactly one result item on the response channel (rsp_valid / rsp_stall)
// with a status code, the new handle on open, and the stored entry fields.
// Handles are generation << 16 | slot + 1; a close bumps the slot's
// generation (skipping zero) so stale handles are rejected.
// Timing: an item is taken at one edge and its slot record is read from the
// record memory into a register; in ST_EXEC, once the result register is free,
// the item is decided, the record written back and the result register loaded,
// which raises rsp_valid. No new item is taken until the current one has been
// written back, since the slot record is read and then written.
// Reset: a clearing pass writes every record's generation to 1 with req_stall
// held high; the occupancy vector clears at once.
// Stall: a result waits in the output register while rsp_stall is high; one
// further item may be accepted and is held before write back until the
// output register frees up.
`default_nettype none

module generational_handle_table_top #(
   parameter int SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_handle,
   input  logic [1:0]  req_access_kind,
   input  logic        req_borrowed,
   input  logic [31:0] req_file_ref,
   input  logic        req_only_if_borrowed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_handle_out,
   output logic [1:0]  rsp_kind_out,
   output logic        rsp_borrowed_out,
   output logic [31:0] rsp_ref_out
);
   import ght_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type sts;

   // Sequencer
   ght_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Slot records, occupancy and result register
   ght_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_action           (req_action),
      .req_handle           (req_handle),
      .req_access_kind      (req_access_kind),
      .req_borrowed         (req_borrowed),
      .req_file_ref         (req_file_ref),
      .req_only_if_borrowed (req_only_if_borrowed),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_handle_out       (rsp_handle_out),
      .rsp_kind_out         (rsp_kind_out),
      .rsp_borrowed_out     (rsp_borrowed_out),
      .rsp_ref_out          (rsp_ref_out)
   );

endmodule

`default_nettype wire

// File: bench/generational_handle_table_checker.sv
`default_nettype none

module generational_handle_table_checker #(
   parameter int SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_handle,
   input  logic [1:0]  req_access_kind,
   input  logic        req_borrowed,
   input  logic [31:0] req_file_ref,
   input  logic        req_only_if_borrowed,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [31:0] rsp_handle_out,
   input  logic [1:0]  rsp_kind_out,
   input  logic        rsp_borrowed_out,
   input  logic [31:0] rsp_ref_out,
   output int          mismatch_count,
   output int          pending_count,
   output int          checked_count,
   output int          full_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import ght_pkg::*;

   // One result item as the table reports it
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] handle;
      logic [1:0]  kind;
      logic        borrowed;
      logic [31:0] obj_ref;
   } table_result_type;

   table_result_type pending_results[$];

   // Shadow copy of the slot table
   logic        slot_busy[SLOTS];
   logic [15:0] slot_gen[SLOTS];
   logic [1:0]  slot_kind[SLOTS];
   logic        slot_lent[SLOTS];
   logic [31:0] slot_obj[SLOTS];

   // Applies one request to the shadow table and returns its result
   function automatic table_result_type apply_request(logic [1:0] act, logic [31:0] h,
                                                      logic [1:0] k, logic b,
                                                      logic [31:0] r, logic oib);
      table_result_type res;
      int               idx;
      logic [15:0]      enc;
      logic [1:0]       stored;
      res = '0;
      idx = -1;
      case (action_type'(act))
         ACT_OPEN: begin
            // bit 1 of the kind wins over bit 0
            stored = k[1] ? KIND_WRITE : (k[0] ? KIND_READ : KIND_NONE);
            if (stored == KIND_NONE) begin
               res.status = STATUS_NO_ACCESS;
            end else begin
               for (int i = SLOTS - 1; i >= 0; i--) begin
                  if (!slot_busy[i]) idx = i;
               end
               if (idx < 0) begin
                  res.status = STATUS_FULL;
               end else begin
                  slot_busy[idx] = 1'b1;
                  slot_kind[idx] = stored;
                  slot_lent[idx] = b;
                  slot_obj[idx]  = r;
                  res.status     = STATUS_OK;
                  res.handle     = {slot_gen[idx], 16'(idx + 1)};
                  res.kind       = stored;
                  res.borrowed   = b;
                  res.obj_ref    = r;
               end
            end
         end
         ACT_CHECK, ACT_CLOSE: begin
            // slot field is slot plus one; zero and out of range are bad
            enc = h[15:0];
            if (enc != 16'd0 && int'(enc) <= SLOTS) begin
               idx = int'(enc) - 1;
               if (!slot_busy[idx] || slot_gen[idx] != h[31:16]) idx = -1;
            end
            if (idx < 0) begin
               res.status = STATUS_BAD_HANDLE;
            end else begin
               res.status   = STATUS_OK;
               res.kind     = slot_kind[idx];
               res.borrowed = slot_lent[idx];
               res.obj_ref  = slot_obj[idx];
               if (action_type'(act) == ACT_CLOSE) begin
                  if (oib && !slot_lent[idx]) begin
                     res.status = STATUS_NOT_BORROWED;
                  end else begin
                     slot_busy[idx] = 1'b0;
                     slot_kind[idx] = KIND_NONE;
                     slot_lent[idx] = 1'b0;
                     // generation skips zero on wrap
                     slot_gen[idx]  = (slot_gen[idx] == 16'hffff) ? 16'd1 : slot_gen[idx] + 16'd1;
                  end
               end
            end
         end
         default: begin
            res.status = STATUS_BAD_HANDLE;
         end
      endcase
      return res;
   endfunction

   // One line per mismatch; printing stops after the first hundred
   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want_v);
      mismatch_count++;
      if (mismatch_count <= 100) begin
         $display("%0t: %s got %0h, expected %0h", $time, field, got, want_v);
      end
   endtask

   // Compare finished items, then predict newly accepted ones
   always @(posedge clock) begin : watch_channels
      table_result_type want_r;
      if (reset) begin
         pending_results.delete();
         for (int i = 0; i < SLOTS; i++) begin
            slot_busy[i] = 1'b0;
            slot_gen[i]  = 16'd1;
            slot_kind[i] = KIND_NONE;
            slot_lent[i] = 1'b0;
            slot_obj[i]  = '0;
         end
         mismatch_count = 0;
         pending_count  = 0;
         checked_count  = 0;
         full_count     = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result item with nothing pending, status", 32'(rsp_status), '0);
            end else begin
               want_r = pending_results.pop_front();
               checked_count++;
               if (rsp_status !== want_r.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want_r.status));
               if (rsp_handle_out !== want_r.handle)
                  report_mismatch("handle_out", rsp_handle_out, want_r.handle);
               if (rsp_kind_out !== want_r.kind)
                  report_mismatch("kind_out", 32'(rsp_kind_out), 32'(want_r.kind));
               if (rsp_borrowed_out !== want_r.borrowed)
                  report_mismatch("borrowed_out", 32'(rsp_borrowed_out), 32'(want_r.borrowed));
               if (rsp_ref_out !== want_r.obj_ref)
                  report_mismatch("ref_out", rsp_ref_out, want_r.obj_ref);
            end
         end
         if (req_valid && !req_stall) begin
            want_r = apply_request(req_action, req_handle, req_access_kind, req_borrowed,
                                   req_file_ref, req_only_if_borrowed);
            if (want_r.status == STATUS_FULL) full_count++;
            pending_results.insert(pending_results.size(), want_r);
         end
         pending_count = pending_results.size();
      end
   end

endmodule

`default_nettype wire

// File: bench/generational_handle_table_top_test.sv
`default_nettype none

module generational_handle_table_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ght_pkg::*;

   localparam int SLOTS        = 64;
   localparam int RANDOM_ITEMS = 1830;
   localparam int IDLE_LIMIT   = 2000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [31:0] req_handle;
   logic [1:0]  req_access_kind;
   logic        req_borrowed;
   logic [31:0] req_file_ref;
   logic        req_only_if_borrowed;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_handle_out;
   logic [1:0]  rsp_kind_out;
   logic        rsp_borrowed_out;
   logic [31:0] rsp_ref_out;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int full_count;

   int   sent_by_action[4];
   int   idle_cycles;
   int   stall_left;
   logic req_idling      = 1'b0;
   logic rsp_idling      = 1'b0;
   logic collect_handles = 1'b0;

   // Live handles carry their borrowed mark in bit 32
   logic [32:0] live_handles[$];
   logic [31:0] retired_handles[$];

   generational_handle_table_top #(.SLOTS(SLOTS)) uut (.*);

   generational_handle_table_checker #(.SLOTS(SLOTS)) u_check (.*);

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] random_ref();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Result-side backpressure
   initial begin
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (rsp_idling && $urandom_range(0, 3) == 0) stall_left = gap_len();
         end
      end
   end

   // Watchdog on channel activity
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Harvest handles from successful opens for later checks and closes
   always @(posedge clock) begin
      if (collect_handles && rsp_valid && !rsp_stall && rsp_status == STATUS_OK &&
          rsp_handle_out != 32'd0) begin
         live_handles.insert(live_handles.size(), {rsp_borrowed_out, rsp_handle_out});
      end
   end

   // Drive one item and hold it until it is taken
   task automatic send_request(action_type act, logic [31:0] h, logic [1:0] k, logic b,
                               logic [31:0] r, logic oib);
      int gap;
      gap = req_idling ? gap_len() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid            <= 1'b1;
      req_action           <= act;
      req_handle           <= h;
      req_access_kind      <= k;
      req_borrowed         <= b;
      req_file_ref         <= r;
      req_only_if_borrowed <= oib;
      do @(posedge clock); while (req_stall);
      sent_by_action[act]++;
   endtask

   // One random item, mostly built around handles the table gave out
   task automatic send_random_item(int open_pct);
      int          pick;
      int          idx;
      logic [32:0] entry;
      logic [31:0] h;
      logic        oib;
      logic [1:0]  k;
      pick = $urandom_range(0, 99);
      k    = ($urandom_range(0, 7) == 0) ? KIND_NONE : 2'($urandom_range(1, 3));
      if (pick < open_pct) begin
         send_request(ACT_OPEN, $urandom, k, 1'($urandom), random_ref(), 1'($urandom));
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 45 && live_handles.size() > 0) begin
            // close a live handle; an owned one stays live when only borrowed may go
            idx   = $urandom_range(0, live_handles.size() - 1);
            entry = live_handles[idx];
            oib   = 1'($urandom);
            if (!oib || entry[32]) begin
               live_handles.delete(idx);
               retired_handles.insert(retired_handles.size(), entry[31:0]);
               if (retired_handles.size() > SLOTS) void'(retired_handles.pop_front());
            end
            send_request(ACT_CLOSE, entry[31:0], 2'($urandom), 1'($urandom), $urandom, oib);
         end else if (pick < 75 && live_handles.size() > 0) begin
            entry = live_handles[$urandom_range(0, live_handles.size() - 1)];
            send_request(ACT_CHECK, entry[31:0], 2'($urandom), 1'($urandom), $urandom,
                         1'($urandom));
         end else if (pick < 85 && retired_handles.size() > 0) begin
            // stale generation
            h = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
            send_request(action_type'($urandom_range(1, 2)), h, 2'($urandom), 1'($urandom),
                         $urandom, 1'($urandom));
         end else if (pick < 90) begin
            send_request(ACT_INVALID, $urandom, 2'($urandom), 1'($urandom), $urandom,
                         1'($urandom));
         end else if (pick < 95 && live_handles.size() > 0) begin
            // live handle with one bit flipped
            entry = live_handles[$urandom_range(0, live_handles.size() - 1)];
            h     = entry[31:0];
            h[5'($urandom_range(0, 31))] ^= 1'b1;
            send_request(action_type'($urandom_range(1, 2)), h, 2'($urandom), 1'($urandom),
                         $urandom, 1'($urandom));
         end else begin
            h = ($urandom_range(0, 1) == 0) ? $urandom :
                {16'($urandom_range(1, 3)), 16'($urandom_range(0, SLOTS + 6))};
            send_request(action_type'($urandom_range(1, 2)), h, 2'($urandom), 1'($urandom),
                         $urandom, 1'($urandom));
         end
      end
   endtask

   // Stimulus and verdict
   initial begin
      int          random_sent;
      int          open_pct;
      int          burst;
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_action           = ACT_OPEN;
      req_handle           = '0;
      req_access_kind      = KIND_NONE;
      req_borrowed         = 1'b0;
      req_file_ref         = '0;
      req_only_if_borrowed = 1'b0;
      idle_cycles          = 0;
      random_sent          = 0;
      foreach (sent_by_action[i]) sent_by_action[i] = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed cases
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      send_request(ACT_OPEN,  32'h0,         KIND_NONE,  1'b0, 32'h1234_5678, 1'b0);
      send_request(ACT_OPEN,  32'hffff_ffff, KIND_READ,  1'b0, 32'h0000_0000, 1'b1);
      send_request(ACT_OPEN,  32'h0,         KIND_WRITE, 1'b1, 32'hffff_ffff, 1'b0);
      send_request(ACT_OPEN,  32'h0,         2'd3,       1'b1, 32'h5a5a_a5a5, 1'b0);
      send_request(ACT_CHECK, 32'h0001_0001, KIND_NONE,  1'b0, 32'h0,         1'b0);
      send_request(ACT_CHECK, 32'hffff_0000, KIND_NONE,  1'b0, 32'h0,         1'b0);
      send_request(ACT_CHECK, 32'h0001_0041, KIND_NONE,  1'b0, 32'h0,         1'b0);
      send_request(ACT_CHECK, 32'hffff_ffff, 2'd3,       1'b1, 32'hffff_ffff, 1'b1);
      send_request(ACT_CHECK, 32'h0001_0004, KIND_NONE,  1'b0, 32'h0,         1'b0);
      send_request(ACT_CHECK, 32'h0002_0001, KIND_NONE,  1'b0, 32'h0,         1'b0);
      send_request(ACT_INVALID, 32'h0001_0001, KIND_READ, 1'b0, 32'h0,        1'b0);
      send_request(ACT_CLOSE, 32'h0001_0001, KIND_NONE,  1'b0, 32'h0,         1'b1);
      send_request(ACT_CLOSE, 32'h0001_0002, KIND_NONE,  1'b0, 32'h0,         1'b1);
      send_request(ACT_CLOSE, 32'h0001_0001, KIND_NONE,  1'b0, 32'h0,         1'b0);
      send_request(ACT_CHECK, 32'h0001_0001, KIND_NONE,  1'b0, 32'h0,         1'b0);
      send_request(ACT_CLOSE, 32'h0001_0002, KIND_NONE,  1'b0, 32'h0,         1'b0);
      send_request(ACT_OPEN,  32'h0,         KIND_READ,  1'b1, 32'h8000_0001, 1'b0);
      send_request(ACT_CLOSE, 32'h0002_0001, KIND_NONE,  1'b0, 32'h0,         1'b0);
      send_request(ACT_CLOSE, 32'h0001_0003, KIND_NONE,  1'b0, 32'h0,         1'b0);

      // Random bursts, each leaning toward filling or draining the table
      collect_handles = 1'b1;
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0:       open_pct = 90;
            1:       open_pct = 60;
            2:       open_pct = 40;
            default: open_pct = 15;
         endcase
         burst      = $urandom_range(40, 150);
         req_idling = ($urandom_range(0, 3) != 0);
         rsp_idling = ($urandom_range(0, 3) != 0);
         repeat (burst) begin
            if (random_sent < RANDOM_ITEMS) begin
               send_random_item(open_pct);
               random_sent++;
            end
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("Sent %0d opens, %0d checks, %0d closes, %0d bad actions; %0d results compared",
               sent_by_action[ACT_OPEN], sent_by_action[ACT_CHECK], sent_by_action[ACT_CLOSE],
               sent_by_action[ACT_INVALID], checked_count);
      $display("Table filled and drained in bursts; %0d table-full replies seen", full_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/ght_pkg.sv
rtl/ght_ctrl.sv
rtl/ght_dp.sv
rtl/generational_handle_table_top.sv
bench/generational_handle_table_checker.sv
bench/generational_handle_table_top_test.sv
